// ----- rtl/scba_pkg.sv -----
`default_nettype none

package scba_pkg;

  localparam int REQ_W        = 16;
  localparam int PAGE_W       = 6;
  localparam int SLOT_W       = 6;
  localparam int OFF_W        = 12;
  localparam int QUOT_W       = 8;
  localparam int CLS_W        = 4;
  localparam int MAP_W        = 63;
  localparam int ENTRY_W      = CLS_W + MAP_W;
  localparam int NUM_CLASSES  = 9;
  localparam int MAX_PAGES    = 64;
  localparam int DEF_NUM_PAGES = 64;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_REQUEST  = 2048;
  localparam int DIV3_MUL     = 171;
  localparam int DIV3_SHIFT   = 9;

  typedef logic [CLS_W-1:0]  cls_t;
  typedef logic [MAP_W-1:0]  map_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [QUOT_W-1:0] quot_t;

  localparam cls_t CLS_16 = 4'd0;
  localparam cls_t CLS_24 = 4'd1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_PAGES  = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  localparam logic [OFF_W-1:0] CLASS_SIZE [NUM_CLASSES] = '{
    12'd16, 12'd24, 12'd32, 12'd64, 12'd128, 12'd256, 12'd512, 12'd1024, 12'd2048
  };
  localparam logic [SLOT_W-1:0] CLASS_SLOTS [NUM_CLASSES] = '{
    6'd63, 6'd63, 6'd63, 6'd62, 6'd31, 6'd15, 6'd7, 6'd3, 6'd1
  };

  function automatic off_t class_size(cls_t c);
    return (c < cls_t'(NUM_CLASSES)) ? CLASS_SIZE[c] : '0;
  endfunction

  function automatic slot_t class_slots(cls_t c);
    return (c < cls_t'(NUM_CLASSES)) ? CLASS_SLOTS[c] : '0;
  endfunction

  function automatic map_t full_mask(cls_t c);
    logic [63:0] w;
    w = (64'd1 << class_slots(c)) - 64'd1;
    return w[MAP_W-1:0];
  endfunction

  function automatic cls_t size_to_class(logic [REQ_W-1:0] bytes);
    cls_t c;
    c = cls_t'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
      if (bytes <= REQ_W'(CLASS_SIZE[i])) c = cls_t'(i);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/scba_ram.sv -----
`default_nettype none

module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/scba_arith.sv -----
`default_nettype none

module scba_arith (
  input  wire scba_pkg::cls_t  cls,
  input  wire scba_pkg::map_t  map_in,
  input  wire scba_pkg::slot_t slot_in,
  input  wire scba_pkg::off_t  offset_in,
  output scba_pkg::slot_t      free_slot,
  output scba_pkg::off_t       slot_offset,
  output scba_pkg::quot_t      quot
);
  import scba_pkg::*;

  map_t        map_inc;
  map_t        lowest_zero;
  logic [17:0] prod;
  logic [17:0] sum;
  off_t        rel;
  logic [8:0]  rel8;
  logic [17:0] div3;
  logic [3:0]  sh;
  off_t        rel_sh;

  // lowest clear occupancy bit
  assign map_inc     = map_in + map_t'(1);
  assign lowest_zero = ~map_in & map_inc;

  always_comb begin
    free_slot = '0;
    for (int i = 0; i < MAP_W; i++) begin
      if (lowest_zero[i]) free_slot = free_slot | SLOT_W'(i);
    end
  end

  // header + slot * class size
  assign prod        = 18'(slot_in) * 18'(class_size(cls));
  assign sum         = prod + 18'(HEADER_BYTES);
  assign slot_offset = sum[OFF_W-1:0];

  // candidate slot from a byte offset; 24-byte class divides by 8 then by 3
  assign rel    = offset_in - OFF_W'(HEADER_BYTES);
  assign rel8   = rel[OFF_W-1:3];
  assign div3   = 18'(rel8) * 18'(DIV3_MUL);
  assign sh     = (cls == CLS_16) ? 4'd4 : (cls + 4'd3);
  assign rel_sh = rel >> sh;
  assign quot   = (cls == CLS_24) ? div3[DIV3_SHIFT+QUOT_W-1:DIV3_SHIFT] : rel_sh[QUOT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/size_class_bitmap_allocator.sv -----
`default_nettype none

// Slab allocator over up to 64 pages, one result per item on done, which is high for exactly
// one cycle and cannot be held off by the receiver. A too-large request, or a free that names
// a page out of range, an unassigned page or an offset below the header, answers the cycle
// after it is taken with busy never raised. Other frees pass through S_FREE_RD and S_FREE_CHK.
// An allocate walks the page table in the page RAM, one page per cycle, and stops at the first
// page of its class with space, else claims the lowest unassigned page, or answers ST_NO_PAGES
// when none is left; a found page passes through S_FIND and S_GRANT. Where busy was raised, done
// rises in the same cycle that busy falls. The page table is empty after reset with no clearing pass.
module size_class_bitmap_allocator #(
  parameter int NUM_PAGES = scba_pkg::DEF_NUM_PAGES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         kind,
  input  wire logic [scba_pkg::REQ_W-1:0]   request_bytes,
  input  wire logic [scba_pkg::PAGE_W-1:0]  free_page,
  input  wire logic [scba_pkg::OFF_W-1:0]   free_offset,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [scba_pkg::PAGE_W-1:0]       grant_page,
  output logic [scba_pkg::SLOT_W-1:0]       grant_slot,
  output logic [scba_pkg::OFF_W-1:0]        grant_offset
);
  import scba_pkg::*;

  localparam int PAGE_SCAN = (NUM_PAGES < MAX_PAGES) ? NUM_PAGES : MAX_PAGES;
  localparam int PAGE_AW   = (PAGE_SCAN > 1) ? $clog2(PAGE_SCAN) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FIND, S_GRANT, S_FREE_RD, S_FREE_CHK
  } state_t;

  state_t               state;
  logic [PAGE_SCAN-1:0] valid;
  cls_t                 req_cls;
  off_t                 req_offset;
  logic [PAGE_W-1:0]    req_page;
  logic [PAGE_AW-1:0]   cur_page;
  logic [PAGE_AW-1:0]   pick;
  logic [PAGE_AW-1:0]   free_pick;
  logic                 found_free;
  map_t                 cur_map;
  slot_t                slot;
  quot_t                q;

  logic                 ram_we;
  logic [PAGE_AW-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [PAGE_AW-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  cls_t                 rd_cls;
  map_t                 rd_map;

  cls_t                 ar_cls;
  slot_t                ar_slot;
  slot_t                ar_free_slot;
  off_t                 ar_offset;
  quot_t                ar_quot;

  logic                 accept;
  logic                 page_ok;
  logic                 is_last;
  logic                 hit;
  logic                 unassigned;
  logic                 free_ok;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign rd_cls = ram_rdata[ENTRY_W-1:MAP_W];
  assign rd_map = ram_rdata[MAP_W-1:0];

  scba_ram #(.WIDTH(ENTRY_W), .DEPTH(PAGE_SCAN)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ar_cls  = (state == S_FREE_RD) ? rd_cls : req_cls;
  assign ar_slot = (state == S_FREE_CHK) ? q[SLOT_W-1:0] : slot;

  scba_arith u_arith (
    .cls         (ar_cls),
    .map_in      (cur_map),
    .slot_in     (ar_slot),
    .offset_in   (req_offset),
    .free_slot   (ar_free_slot),
    .slot_offset (ar_offset),
    .quot        (ar_quot)
  );

  assign page_ok = ({1'b0, free_page} < (PAGE_W+1)'(PAGE_SCAN)) &&
                   valid[free_page[PAGE_AW-1:0]];
  assign is_last = (cur_page == PAGE_AW'(PAGE_SCAN - 1));
  assign unassigned = !valid[cur_page];
  assign hit = valid[cur_page] && (rd_cls == req_cls) &&
               ((rd_map & full_mask(req_cls)) != full_mask(req_cls));
  assign free_ok = (req_cls < cls_t'(NUM_CLASSES)) &&
                   (q < QUOT_W'(class_slots(req_cls))) &&
                   (ar_offset == req_offset) &&
                   cur_map[q[SLOT_W-1:0]];

  always_comb begin
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = pick;
    ram_wdata = {req_cls, cur_map | (map_t'(1) << slot)};
    case (state)
      S_IDLE: begin
        if (kind == KIND_FREE) ram_raddr = free_page[PAGE_AW-1:0];
      end
      S_SCAN: begin
        if (!is_last) ram_raddr = cur_page + PAGE_AW'(1);
      end
      S_GRANT: begin
        ram_we = 1'b1;
      end
      S_FREE_CHK: begin
        ram_we    = free_ok;
        ram_waddr = req_page[PAGE_AW-1:0];
        ram_wdata = {req_cls, cur_map & ~(map_t'(1) << q[SLOT_W-1:0])};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_page   <= free_page;
            req_offset <= free_offset;
            req_cls    <= size_to_class(request_bytes);
            cur_page   <= '0;
            found_free <= 1'b0;
            if (kind == KIND_ALLOC) begin
              if (request_bytes > REQ_W'(MAX_REQUEST)) begin
                done         <= 1'b1;
                status       <= ST_TOO_LARGE;
                grant_page   <= '0;
                grant_slot   <= '0;
                grant_offset <= '0;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              if (!page_ok || (free_offset < OFF_W'(HEADER_BYTES))) begin
                done         <= 1'b1;
                status       <= ST_BAD_FREE;
                grant_page   <= '0;
                grant_slot   <= '0;
                grant_offset <= '0;
              end else begin
                state <= S_FREE_RD;
              end
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            pick    <= cur_page;
            cur_map <= rd_map;
            state   <= S_FIND;
          end else if (is_last) begin
            if (found_free || unassigned) begin
              pick    <= found_free ? free_pick : cur_page;
              cur_map <= '0;
              state   <= S_FIND;
            end else begin
              done         <= 1'b1;
              status       <= ST_NO_PAGES;
              grant_page   <= '0;
              grant_slot   <= '0;
              grant_offset <= '0;
              state        <= S_IDLE;
            end
          end else begin
            cur_page <= cur_page + PAGE_AW'(1);
            if (unassigned && !found_free) begin
              found_free <= 1'b1;
              free_pick  <= cur_page;
            end
          end
        end
        S_FIND: begin
          slot  <= ar_free_slot;
          state <= S_GRANT;
        end
        S_GRANT: begin
          valid[pick]  <= 1'b1;
          done         <= 1'b1;
          status       <= ST_OK;
          grant_page   <= PAGE_W'(pick);
          grant_slot   <= slot;
          grant_offset <= ar_offset;
          state        <= S_IDLE;
        end
        S_FREE_RD: begin
          req_cls <= rd_cls;
          cur_map <= rd_map;
          q       <= ar_quot;
          state   <= S_FREE_CHK;
        end
        S_FREE_CHK: begin
          done <= 1'b1;
          if (free_ok) begin
            status       <= ST_OK;
            grant_page   <= req_page;
            grant_slot   <= q[SLOT_W-1:0];
            grant_offset <= req_offset;
          end else begin
            status       <= ST_BAD_FREE;
            grant_page   <= '0;
            grant_slot   <= '0;
            grant_offset <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |->
      (grant_page == '0 && grant_slot == '0 && grant_offset == '0))
    else $error("error result with nonzero grant");

  a_too_large: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_ALLOC) && (request_bytes > REQ_W'(MAX_REQUEST))) |=>
      (done && (status == ST_TOO_LARGE)))
    else $error("oversize request not rejected");

  a_ok_offset: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_OK)) |-> (grant_offset >= OFF_W'(HEADER_BYTES)))
    else $error("granted offset inside page header");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import scba_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 80;
  localparam logic [3:0] NO_CLASS = 4'd15;

  typedef struct packed {
    logic        kind;
    logic [15:0] bytes;
    logic [5:0]  page;
    logic [11:0] offset;
    logic        drain_first;
  } slab_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  page;
    logic [5:0]  slot;
    logic [11:0] offset;
  } slab_reply_t;

  typedef struct packed {
    logic [5:0]  page;
    logic [11:0] offset;
  } block_ref_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        kind = KIND_ALLOC;
  logic [15:0] request_bytes = '0;
  logic [5:0]  free_page = '0;
  logic [11:0] free_offset = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [5:0]  grant_page;
  logic [5:0]  grant_slot;
  logic [11:0] grant_offset;

  // shadow allocator state
  logic [3:0]  page_cls [64];
  logic [62:0] slot_bits [64];

  slab_cmd_t   cmd_backlog [$];
  slab_reply_t replies_due [$];
  block_ref_t  live_blocks [$];
  slab_cmd_t   in_flight;
  slab_reply_t reply;
  slab_reply_t want;
  block_ref_t  blk;
  block_ref_t  last_freed;
  bit          freed_any = 1'b0;
  bit          took_item = 1'b0;
  int          gap_left = 0;
  int          calm_left = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  size_class_bitmap_allocator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .request_bytes(request_bytes),
    .free_page(free_page),
    .free_offset(free_offset),
    .done(done),
    .status(status),
    .grant_page(grant_page),
    .grant_slot(grant_slot),
    .grant_offset(grant_offset)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int slab_bytes(int c);
    case (c)
      0: return 16;
      1: return 24;
      2: return 32;
      3: return 64;
      4: return 128;
      5: return 256;
      6: return 512;
      7: return 1024;
      default: return 2048;
    endcase
  endfunction

  function automatic int slab_slots(int c);
    case (c)
      0, 1, 2: return 63;
      3: return 62;
      4: return 31;
      5: return 15;
      6: return 7;
      7: return 3;
      default: return 1;
    endcase
  endfunction

  function automatic slab_reply_t predict_reply(slab_cmd_t c);
    slab_reply_t r;
    int cls;
    int pick;
    int slot;
    int rel;
    int size;
    logic [63:0] wide;
    logic [62:0] full;
    r = '0;
    r.status = ST_OK;
    if (c.kind == KIND_ALLOC) begin
      if (int'(c.bytes) > MAX_REQUEST) begin
        r.status = ST_TOO_LARGE;
      end else begin
        cls = 0;
        while (cls < NUM_CLASSES - 1 && int'(c.bytes) > slab_bytes(cls)) cls++;
        wide = (64'd1 << slab_slots(cls)) - 64'd1;
        full = wide[62:0];
        pick = -1;
        for (int p = 0; p < 64; p++) begin
          if (pick < 0 && page_cls[p] == 4'(cls) && (slot_bits[p] & full) != full) pick = p;
        end
        for (int p = 0; p < 64; p++) begin
          if (pick < 0 && page_cls[p] == NO_CLASS) begin
            pick = p;
            page_cls[p] = 4'(cls);
            slot_bits[p] = '0;
          end
        end
        if (pick < 0) begin
          r.status = ST_NO_PAGES;
        end else begin
          slot = 0;
          while (slot < slab_slots(cls) && slot_bits[pick][slot]) slot++;
          slot_bits[pick][slot] = 1'b1;
          r.page = 6'(pick);
          r.slot = 6'(slot);
          r.offset = 12'(HEADER_BYTES + slot * slab_bytes(cls));
        end
      end
    end else begin
      cls = int'(page_cls[c.page]);
      if (cls >= NUM_CLASSES || int'(c.offset) < HEADER_BYTES) begin
        r.status = ST_BAD_FREE;
      end else begin
        rel = int'(c.offset) - HEADER_BYTES;
        size = slab_bytes(cls);
        slot = rel / size;
        if (rel % size != 0 || slot >= slab_slots(cls) || !slot_bits[c.page][slot]) begin
          r.status = ST_BAD_FREE;
        end else begin
          slot_bits[c.page][slot] = 1'b0;
          r.page = c.page;
          r.slot = 6'(slot);
          r.offset = c.offset;
        end
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 70);
  endfunction

  function automatic logic [15:0] pick_bytes(bit big_bias);
    int r;
    int cls;
    int lo;
    r = $urandom_range(0, 99);
    if (r < 3) return 16'($urandom_range(MAX_REQUEST + 1, 65535));
    if (r < 5) return 16'($urandom);
    if (big_bias && r < 75) cls = $urandom_range(7, 8);
    else if (!big_bias && r < 40) cls = $urandom_range(0, 1);
    else cls = $urandom_range(0, NUM_CLASSES - 1);
    lo = (cls == 0) ? 0 : slab_bytes(cls - 1) + 1;
    return 16'($urandom_range(lo, slab_bytes(cls)));
  endfunction

  task automatic queue_cmd(logic k, logic [15:0] b, logic [5:0] pg, logic [11:0] off,
                           bit drain);
    slab_cmd_t c;
    c.kind = k;
    c.bytes = b;
    c.page = pg;
    c.offset = off;
    c.drain_first = drain;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_random_items(int count, bit big_bias, int alloc_pct);
    int r;
    int idx;
    block_ref_t b;
    logic [5:0] pg;
    logic [11:0] off;
    for (int n = 0; n < count; n++) begin
      while (cmd_backlog.size() > 1) @(posedge clk);
      r = $urandom_range(0, 99);
      pg = 6'($urandom);
      off = 12'($urandom);
      if (r < alloc_pct) begin
        queue_cmd(KIND_ALLOC, pick_bytes(big_bias), pg, off, n == 0);
      end else begin
        r = $urandom_range(0, 99);
        if (live_blocks.size() != 0 && r < 75) begin
          idx = $urandom_range(0, live_blocks.size() - 1);
          b = live_blocks[idx];
          live_blocks.delete(idx);
          pg = b.page;
          off = b.offset;
          last_freed = b;
          freed_any = 1'b1;
        end else if (live_blocks.size() != 0 && r < 85) begin
          // near miss on a live block
          idx = $urandom_range(0, live_blocks.size() - 1);
          b = live_blocks[idx];
          pg = b.page;
          off = b.offset + 12'($urandom_range(1, 40));
        end else if (freed_any && r < 92) begin
          pg = last_freed.page;
          off = last_freed.offset;
        end
        queue_cmd(KIND_FREE, 16'($urandom), pg, off, n == 0);
      end
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (took_item) begin
        reply = predict_reply(in_flight);
        replies_due.push_back(reply);
        if (in_flight.kind == KIND_ALLOC && reply.status == ST_OK) begin
          blk.page = reply.page;
          blk.offset = reply.offset;
          live_blocks.push_back(blk);
        end
        gap_left = pick_gap();
      end
      if (!start || took_item) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].drain_first && replies_due.size() != 0)) begin
          in_flight = cmd_backlog.pop_front();
          kind <= in_flight.kind;
          request_bytes <= in_flight.bytes;
          free_page <= in_flight.page;
          free_offset <= in_flight.offset;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    took_item = !rst && start && !busy;
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: expected no item, got status %0d page %0d slot %0d offset %0d", $time,
                 status, grant_page, grant_slot, grant_offset);
      end else begin
        want = replies_due.pop_front();
        if (status !== want.status || grant_page !== want.page ||
            grant_slot !== want.slot || grant_offset !== want.offset) begin
          mismatches++;
          $display("%0t: expected status %0d page %0d slot %0d offset %0d, got %0d %0d %0d %0d",
                   $time, want.status, want.page, want.slot, want.offset,
                   status, grant_page, grant_slot, grant_offset);
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL size_class_bitmap_allocator");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < 64; p++) begin
      page_cls[p] = NO_CLASS;
      slot_bits[p] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_cmd(KIND_ALLOC, 16'd0, 6'h3f, 12'hfff, 1'b0);
    queue_cmd(KIND_ALLOC, 16'd16, 6'd0, 12'd0, 1'b0);
    queue_cmd(KIND_ALLOC, 16'd17, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_ALLOC, 16'd25, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_ALLOC, 16'd33, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_ALLOC, 16'd65, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_ALLOC, 16'd129, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_ALLOC, 16'd257, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_ALLOC, 16'd513, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_ALLOC, 16'd1025, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_ALLOC, 16'd2048, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_ALLOC, 16'd2049, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_ALLOC, 16'hffff, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_FREE, 16'hffff, 6'd0, 12'd24, 1'b0);
    queue_cmd(KIND_FREE, 16'd0, 6'd0, 12'd24, 1'b0);      // double free
    queue_cmd(KIND_ALLOC, 16'd1, 6'($urandom), 12'($urandom), 1'b0);
    queue_cmd(KIND_FREE, 16'($urandom), 6'd0, 12'd0, 1'b0);
    queue_cmd(KIND_FREE, 16'($urandom), 6'd0, 12'd25, 1'b0);
    queue_cmd(KIND_FREE, 16'($urandom), 6'd1, 12'd40, 1'b0);
    queue_cmd(KIND_FREE, 16'($urandom), 6'd8, 12'd2072, 1'b0); // past page capacity
    queue_cmd(KIND_FREE, 16'($urandom), 6'd63, 12'd24, 1'b0);  // unassigned page
    queue_cmd(KIND_FREE, 16'($urandom), 6'd63, 12'hfff, 1'b0);
    queue_cmd(KIND_FREE, 16'($urandom), 6'd9, 12'd24, 1'b0);
    queue_cmd(KIND_FREE, 16'($urandom), 6'd0, 12'hfff, 1'b0);

    queue_random_items(300, 1'b0, 70);
    queue_random_items(150, 1'b1, 85);  // runs the pool out of pages
    queue_random_items(300, 1'b0, 55);

    while (cmd_backlog.size() != 0 || start || replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS size_class_bitmap_allocator");
    end else begin
      $display("FAIL size_class_bitmap_allocator");
    end
    $finish;
  end

endmodule
